>>> rtl/lcd_pkg.sv
// lcd_pkg: shared types and codes for the lane change decision block
// holds the input and result word layouts carried by the channel interfaces
// no dependencies
package lcd_pkg;

	localparam int unsigned PosW  = 17;
	localparam int unsigned LaneW = 3;

	// op codes of the input word
	localparam logic [1:0] OpEgo     = 2'd0;
	localparam logic [1:0] OpVehicle = 2'd1;
	localparam logic [1:0] OpDecide  = 2'd2;

	// speed action codes of the result word
	localparam logic [1:0] ActHold  = 2'd0;
	localparam logic [1:0] ActAccel = 2'd1;
	localparam logic [1:0] ActDecel = 2'd2;

	// next_state codes of the result word
	localparam logic [1:0] StFollow = 2'd0;
	localparam logic [1:0] StLeft   = 2'd1;
	localparam logic [1:0] StRight  = 2'd2;

	// register indexes and reset values
	localparam logic RegSafetyDistance = 1'b0;
	localparam logic RegStartLane      = 1'b1;
	localparam logic [PosW-1:0]  SafetyDistanceReset = 17'd480;
	localparam logic [LaneW-1:0] StartLaneReset      = 3'd1;

	typedef struct packed {
		logic [1:0]       op;
		logic [LaneW-1:0] lane;
		logic [PosW-1:0]  position;
	} in_word_t;

	typedef struct packed {
		logic [1:0]       next_state;
		logic [LaneW-1:0] target_lane_out;
		logic [1:0]       speed_action;
	} out_word_t;

endpackage

>>> rtl/lcd_in_if.sv
// lcd_in_if: valid/ready channel carrying one input word
// depends on lcd_pkg for the word layout
interface lcd_in_if;
	logic             valid;
	logic             ready;
	lcd_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lcd_out_if.sv
// lcd_out_if: valid/ready channel carrying one result word
// depends on lcd_pkg for the word layout
interface lcd_out_if;
	logic              valid;
	logic              ready;
	lcd_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lane_change_decision_fsm.sv
// lane_change_decision_fsm: lane change decision machine, top level
// depends on lcd_pkg, lcd_in_if and lcd_out_if
//
// Takes one word per clock on the item channel unless stalled. An ego word
// sets the own lane and position and clears the trackers, a vehicle word
// updates the nearest gap ahead in the own lane and the blocked flags, and
// a decide word runs the follow / change-left / change-right machine and
// gives exactly one result word; ego and vehicle words give none, as does
// the unused op code. Each word is captured in an input register and then
// handled by short logic that updates the trackers and loads the result
// register, so the sustained rate is one word per cycle when nothing stalls,
// and a decide result leaves from the result register. The input register waits only while
// it holds a decide word and the result register still holds a word that
// has not been taken. Configuration writes (safety distance, start lane) are
// meant for an idle block; a start lane write also reloads the target lane.
module lane_change_decision_fsm #(
	parameter int unsigned LANE_COUNT = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	lcd_in_if.sink                   item,
	lcd_out_if.source                result,
	input  logic                     wr_en,
	input  logic                     wr_index,
	input  logic [lcd_pkg::PosW-1:0] wr_data
);

	localparam int unsigned PosW   = lcd_pkg::PosW;
	localparam int unsigned LaneW  = lcd_pkg::LaneW;
	// bits needed to index the blocked flags
	localparam int unsigned IdxW   = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
	// lane limit one bit wider than a lane so that own_lane + 1 fits
	localparam logic [LaneW:0] LaneLimit = (LaneW + 1)'(LANE_COUNT);

	typedef enum logic [1:0] {
		MODE_FOLLOW = 2'd0,
		MODE_LEFT   = 2'd1,
		MODE_RIGHT  = 2'd2
	} mode_t;

	// input register
	logic              valid_s1;
	lcd_pkg::in_word_t word_s1;

	// block state
	mode_t             mode_q;
	logic [LaneW-1:0]  heading_q;
	logic [LaneW-1:0]  own_lane_q;
	logic [PosW-1:0]   own_pos_q;
	logic              ahead_found_q;
	logic [PosW-1:0]   ahead_gap_q;
	logic [LANE_COUNT-1:0] blocked_q;
	logic [PosW-1:0]   safety_q;

	// result register
	logic              out_valid_q;
	lcd_pkg::out_word_t out_word_q;

	logic              is_decide;
	logic              advance;
	logic              take_item;

	// next-state values from the handled word
	mode_t             mode_d;
	logic [LaneW-1:0]  heading_d;
	logic [1:0]        act_d;

	// vehicle tracking
	logic              veh_in_range;
	logic              veh_behind;
	logic [PosW-1:0]   gap_fwd;
	logic [PosW-1:0]   abs_gap;
	logic              veh_close;
	logic              veh_nearer;

	// neighbor lanes
	logic [LaneW:0]    right_lane;
	logic [LaneW-1:0]  left_lane;
	logic              left_free;
	logic              right_free;
	logic              too_close;

	// the input register moves on unless a decide word meets a full, stalled result
	assign is_decide = (word_s1.op == lcd_pkg::OpDecide);
	assign advance   = !valid_s1 || !is_decide || !out_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign take_item  = item.valid && item.ready;

	assign result.valid = out_valid_q;
	assign result.data  = out_word_q;

	// vehicle distance and gap
	assign veh_in_range = ({1'b0, word_s1.lane} < LaneLimit);
	assign veh_behind   = (word_s1.position < own_pos_q);
	assign gap_fwd      = word_s1.position - own_pos_q;
	assign abs_gap      = veh_behind ? (own_pos_q - word_s1.position) : gap_fwd;
	assign veh_close    = (abs_gap <= safety_q);
	assign veh_nearer   = !ahead_found_q || (gap_fwd < ahead_gap_q);

	// lane to the left is own - 1, to the right own + 1
	assign left_lane  = own_lane_q - 3'd1;
	assign right_lane = {1'b0, own_lane_q} + 4'd1;
	assign left_free  = (own_lane_q != '0) && ({1'b0, left_lane} < LaneLimit)
		&& !blocked_q[left_lane[IdxW-1:0]];
	assign right_free = (right_lane < LaneLimit) && !blocked_q[right_lane[IdxW-1:0]];
	assign too_close  = ahead_found_q && (ahead_gap_q != '0) && (ahead_gap_q < safety_q);

	// decision on a decide word
	always_comb begin
		mode_d    = mode_q;
		heading_d = heading_q;
		act_d     = lcd_pkg::ActHold;
		case (mode_q)
			MODE_LEFT, MODE_RIGHT: begin
				// change done once the own lane reaches the target
				if (own_lane_q == heading_q) begin
					mode_d = MODE_FOLLOW;
				end
			end
			default: begin
				if (too_close) begin
					if (left_free) begin
						mode_d    = MODE_LEFT;
						heading_d = left_lane;
					end else if (right_free) begin
						mode_d    = MODE_RIGHT;
						heading_d = right_lane[LaneW-1:0];
					end else begin
						mode_d = MODE_FOLLOW;
						act_d  = lcd_pkg::ActDecel;
					end
				end else begin
					mode_d = MODE_FOLLOW;
					act_d  = lcd_pkg::ActAccel;
				end
			end
		endcase
	end

	// input payload register
	always_ff @(posedge clk) begin
		if (take_item) begin
			word_s1 <= item.data;
		end
	end

	// state, trackers and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			mode_q        <= MODE_FOLLOW;
			heading_q     <= lcd_pkg::StartLaneReset;
			own_lane_q    <= '0;
			own_pos_q     <= '0;
			ahead_found_q <= 1'b0;
			ahead_gap_q   <= '0;
			blocked_q     <= '0;
			safety_q      <= lcd_pkg::SafetyDistanceReset;
			out_valid_q   <= 1'b0;
			out_word_q    <= '0;
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (wr_en) begin
				case (wr_index)
					lcd_pkg::RegSafetyDistance: safety_q  <= wr_data;
					lcd_pkg::RegStartLane:      heading_q <= wr_data[LaneW-1:0];
					default: ;
				endcase
			end
			if (valid_s1 && advance) begin
				case (word_s1.op)
					lcd_pkg::OpEgo: begin
						own_lane_q    <= word_s1.lane;
						own_pos_q     <= word_s1.position;
						ahead_found_q <= 1'b0;
						ahead_gap_q   <= '0;
						blocked_q     <= '0;
					end
					lcd_pkg::OpVehicle: begin
						if (veh_in_range) begin
							if (veh_close) begin
								blocked_q[word_s1.lane[IdxW-1:0]] <= 1'b1;
							end
							if ((word_s1.lane == own_lane_q) && !veh_behind && veh_nearer) begin
								ahead_found_q <= 1'b1;
								ahead_gap_q   <= gap_fwd;
							end
						end
					end
					lcd_pkg::OpDecide: begin
						mode_q                     <= mode_d;
						heading_q                  <= heading_d;
						out_valid_q                <= 1'b1;
						out_word_q.next_state      <= mode_d;
						out_word_q.target_lane_out <= heading_d;
						out_word_q.speed_action    <= act_d;
					end
					default: ;
				endcase
			end
		end
	end

	// a lane change result never comes with a speed change
	a_change_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.next_state == lcd_pkg::StFollow
			|| result.data.speed_action == lcd_pkg::ActHold))
		else $error("lane change result with speed action");

	// only a decide word fills an empty result register
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !is_decide && !out_valid_q) |=> !result.valid)
		else $error("result without decide word");

	// the item side stalls only behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (result.valid && !result.ready))
		else $error("item channel stalled without cause");

endmodule

>>> test/tb_top.sv
// tb_top: self-checking bench for lane_change_decision_fsm, directed table then random traffic
// depends on lcd_pkg, lcd_in_if, lcd_out_if and the block itself
// decide results are predicted in the bench and checked word by word in arrival order
`timescale 1ns / 100ps

module tb_top;

	localparam int LANE_COUNT = 3;
	localparam int PHASES = 6;
	localparam int WORDS_PER_PHASE = 145;
	// long receiver hold-off so the input register backs up behind a decide
	localparam int LONG_HOLD = 400;
	// run limit, with lots of room over the slowest correct run
	localparam int CYCLE_LIMIT = 400000;
	// extra wait once every owed decision has arrived
	localparam int SETTLE = 4;

	logic                     clk;
	logic                     arst_n;
	logic                     wr_en;
	logic                     wr_index;
	logic [lcd_pkg::PosW-1:0] wr_data;

	lcd_in_if  item_ch ();
	lcd_out_if result_ch ();

	lane_change_decision_fsm #(
		.LANE_COUNT(LANE_COUNT)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// ------------------------------------------------------------------
	// clock and run limit
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// decision predictor: own copy of the registers and trackers
	// ------------------------------------------------------------------
	logic [lcd_pkg::PosW-1:0]  safety_q;
	logic [lcd_pkg::LaneW-1:0] start_lane_q;
	logic [1:0]                mode_q;
	logic [lcd_pkg::LaneW-1:0] heading_q;
	logic [lcd_pkg::LaneW-1:0] own_lane_q;
	logic [lcd_pkg::PosW-1:0]  own_pos_q;
	bit                        ahead_found_q;
	logic [lcd_pkg::PosW-1:0]  ahead_gap_q;
	bit [LANE_COUNT-1:0]       lane_blocked_q;

	// decisions still owed by the block, oldest first
	lcd_pkg::out_word_t pending_decisions[$];

	int mismatch_count = 0;
	int decisions_seen = 0;
	int words_sent = 0;
	int reg_writes = 0;
	// percent chance of a gap before a word / a stall on the result side
	int idle_pct = 25;

	// one input word through the trackers and the follow / change machine;
	// returns 1 when the word gives a decision
	function automatic bit decide_lanes(input lcd_pkg::in_word_t w,
		output lcd_pkg::out_word_t r);
		logic [lcd_pkg::PosW-1:0] abs_gap;
		logic [lcd_pkg::PosW-1:0] gap;
		logic [1:0]               act;
		int                       left_l;
		int                       right_l;
		r = '0;
		case (w.op)
			lcd_pkg::OpEgo: begin
				own_lane_q = w.lane;
				own_pos_q = w.position;
				ahead_found_q = 1'b0;
				ahead_gap_q = '0;
				lane_blocked_q = '0;
				return 1'b0;
			end
			lcd_pkg::OpVehicle: begin
				// vehicles beyond the last lane are dropped
				if (w.lane >= LANE_COUNT)
					return 1'b0;
				abs_gap = (w.position >= own_pos_q) ? w.position - own_pos_q
					: own_pos_q - w.position;
				if (abs_gap <= safety_q)
					lane_blocked_q[w.lane] = 1'b1;
				// nearest one at or ahead of us in our lane; ties keep the first
				if (w.lane == own_lane_q && w.position >= own_pos_q) begin
					gap = w.position - own_pos_q;
					if (!ahead_found_q || gap < ahead_gap_q) begin
						ahead_found_q = 1'b1;
						ahead_gap_q = gap;
					end
				end
				return 1'b0;
			end
			lcd_pkg::OpDecide: begin
				act = lcd_pkg::ActHold;
				left_l = int'(own_lane_q) - 1;
				right_l = int'(own_lane_q) + 1;
				if (mode_q == lcd_pkg::StLeft || mode_q == lcd_pkg::StRight) begin
					// lane change ends once the ego reports the target lane
					if (own_lane_q == heading_q)
						mode_q = lcd_pkg::StFollow;
				end else if (ahead_found_q && ahead_gap_q > 0 && ahead_gap_q < safety_q) begin
					// someone too close ahead: left first, then right, else slow down
					if (left_l >= 0 && left_l < LANE_COUNT && !lane_blocked_q[left_l]) begin
						heading_q = 3'(left_l);
						mode_q = lcd_pkg::StLeft;
					end else if (right_l < LANE_COUNT && !lane_blocked_q[right_l]) begin
						heading_q = 3'(right_l);
						mode_q = lcd_pkg::StRight;
					end else begin
						mode_q = lcd_pkg::StFollow;
						act = lcd_pkg::ActDecel;
					end
				end else begin
					// road clear (also covers an own lane past the last one)
					mode_q = lcd_pkg::StFollow;
					act = lcd_pkg::ActAccel;
				end
				r.next_state = mode_q;
				r.target_lane_out = heading_q;
				r.speed_action = act;
				return 1'b1;
			end
			default: return 1'b0; // unused op code
		endcase
	endfunction

	// ------------------------------------------------------------------
	// gaps: a short one 88 times in 100, else a long one
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 88)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ------------------------------------------------------------------
	// word sender: offer one word, wait for the handshake, then predict.
	// a typed row overrides the predicted decision with its own value
	// ------------------------------------------------------------------
	task automatic offer_word(input lcd_pkg::in_word_t w, input bit typed,
		input lcd_pkg::out_word_t typed_r);
		int                 g;
		lcd_pkg::out_word_t r;
		g = 0;
		if ($urandom_range(0, 99) < idle_pct)
			g = pick_gap();
		if (g > 0) begin
			item_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= w;
		// ready read right after the edge is the value the edge sampled
		do @(posedge clk); while (!item_ch.ready);
		words_sent++;
		if (decide_lanes(w, r))
			pending_decisions.insert(pending_decisions.size(), typed ? typed_r : r);
	endtask

	task automatic offer(input logic [1:0] op, input logic [lcd_pkg::LaneW-1:0] ln,
		input logic [lcd_pkg::PosW-1:0] pos);
		offer_word('{op: op, lane: ln, position: pos}, 1'b0, '0);
	endtask

	// stop offering, let every owed decision arrive plus the pipeline tail
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (pending_decisions.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// register write on an idle block; the caller drops wr_en afterwards
	task automatic write_reg(input logic idx, input logic [lcd_pkg::PosW-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		reg_writes++;
		if (idx == lcd_pkg::RegSafetyDistance) begin
			safety_q = val;
		end else begin
			// start lane also reloads the heading lane at once
			start_lane_q = val[lcd_pkg::LaneW-1:0];
			heading_q = val[lcd_pkg::LaneW-1:0];
		end
	endtask

	// ------------------------------------------------------------------
	// directed table: corner cases with hand-read results where obvious
	// ------------------------------------------------------------------
	typedef struct {
		lcd_pkg::in_word_t  w;
		bit                 typed;
		lcd_pkg::out_word_t r;
	} plan_row_t;

	plan_row_t corner_plan[$];

	task automatic add_row(input logic [1:0] op, input int ln, input int pos,
		input bit typed = 1'b0, input logic [1:0] ns = lcd_pkg::StFollow,
		input int tl = 0, input logic [1:0] sa = lcd_pkg::ActHold);
		plan_row_t row;
		row.w = '{op: op, lane: 3'(ln), position: 17'(pos)};
		row.typed = typed;
		row.r = '{next_state: ns, target_lane_out: 3'(tl), speed_action: sa};
		corner_plan.insert(corner_plan.size(), row);
	endtask

	task automatic build_corner_plan();
		// first decide after reset: nothing around, go faster toward start lane
		add_row(lcd_pkg::OpDecide, 0, 0, 1'b1, lcd_pkg::StFollow, 1, lcd_pkg::ActAccel);
		// close car ahead, both side lanes taken (right one exactly at the limit)
		add_row(lcd_pkg::OpEgo, 1, 1000);
		add_row(lcd_pkg::OpVehicle, 1, 1100);
		add_row(lcd_pkg::OpVehicle, 0, 1000);
		add_row(lcd_pkg::OpVehicle, 2, 1480);
		add_row(lcd_pkg::OpDecide, 5, 77, 1'b1, lcd_pkg::StFollow, 1, lcd_pkg::ActDecel);
		// left lane one step past the limit: free, so change left
		add_row(lcd_pkg::OpEgo, 1, 1000);
		add_row(lcd_pkg::OpVehicle, 1, 1100);
		add_row(lcd_pkg::OpVehicle, 0, 1481);
		add_row(lcd_pkg::OpDecide, 0, 0, 1'b1, lcd_pkg::StLeft, 0, lcd_pkg::ActHold);
		// ego arrives in the target lane: back to follow
		add_row(lcd_pkg::OpEgo, 0, 2000);
		add_row(lcd_pkg::OpDecide, 0, 0, 1'b1, lcd_pkg::StFollow, 0, lcd_pkg::ActHold);
		// lane past the last one and the unused op code are both dropped
		add_row(lcd_pkg::OpVehicle, 3, 2010);
		add_row(2'd3, 5, 2001);
		// car right beside us: a gap of zero does not count as too close
		add_row(lcd_pkg::OpVehicle, 0, 2000);
		add_row(lcd_pkg::OpDecide, 0, 0, 1'b1, lcd_pkg::StFollow, 0, lcd_pkg::ActAccel);
		// two equal gaps ahead, no left lane, right is free
		add_row(lcd_pkg::OpEgo, 0, 2000);
		add_row(lcd_pkg::OpVehicle, 0, 2050);
		add_row(lcd_pkg::OpVehicle, 0, 2050);
		add_row(lcd_pkg::OpDecide, 7, 131071, 1'b1, lcd_pkg::StRight, 1, lcd_pkg::ActHold);
		// still changing while the ego is somewhere else
		add_row(lcd_pkg::OpEgo, 7, 131071);
		add_row(lcd_pkg::OpDecide, 0, 0, 1'b1, lcd_pkg::StRight, 1, lcd_pkg::ActHold);
		// far car ahead at the top of the range, ego reached target
		add_row(lcd_pkg::OpEgo, 1, 0);
		add_row(lcd_pkg::OpVehicle, 1, 131071);
		add_row(lcd_pkg::OpDecide, 0, 0, 1'b1, lcd_pkg::StFollow, 1, lcd_pkg::ActHold);
		// own lane past the last one: nothing can be ahead
		add_row(lcd_pkg::OpEgo, 7, 5);
		add_row(lcd_pkg::OpDecide, 2, 65536);
	endtask

	// ------------------------------------------------------------------
	// random traffic: mostly ego / vehicles / decide scenes, some noise
	// ------------------------------------------------------------------
	task automatic run_traffic(input int target);
		int                        counted;
		int                        span;
		int                        off;
		logic [lcd_pkg::LaneW-1:0] ego_lane;
		logic [lcd_pkg::LaneW-1:0] ln;
		logic [lcd_pkg::PosW-1:0]  base;
		logic [lcd_pkg::PosW-1:0]  p;
		logic [1:0]                op;
		counted = 0;
		while (counted < target) begin
			if ($urandom_range(0, 99) < 85) begin
				// during a lane change, often report the target lane so it completes
				if (mode_q != lcd_pkg::StFollow && $urandom_range(0, 1))
					ego_lane = heading_q;
				else if ($urandom_range(0, 9) == 0)
					ego_lane = 3'($urandom_range(0, 7));
				else
					ego_lane = 3'($urandom_range(0, LANE_COUNT - 1));
				case ($urandom_range(0, 19))
					0: base = '0;
					1: base = '1;
					default: base = 17'($urandom_range(0, 131071));
				endcase
				offer(lcd_pkg::OpEgo, ego_lane, base);
				counted++;
				// cars scattered around the ego, about half in its lane
				span = 2 * int'(safety_q) + 32;
				repeat ($urandom_range(0, 5)) begin
					if ($urandom_range(0, 1))
						ln = ego_lane;
					else if ($urandom_range(0, 9) == 0)
						ln = 3'($urandom_range(0, 7));
					else
						ln = 3'($urandom_range(0, LANE_COUNT - 1));
					off = int'($urandom_range(0, 2 * span)) - span;
					p = 17'(int'(base) + off);
					offer(lcd_pkg::OpVehicle, ln, p);
					if (ln < LANE_COUNT)
						counted++;
				end
				repeat ($urandom_range(1, 2)) begin
					offer(lcd_pkg::OpDecide, 3'($urandom_range(0, 7)),
						17'($urandom_range(0, 131071)));
					counted++;
				end
			end else begin
				// noise: any op, any lane, any position
				op = 2'($urandom_range(0, 3));
				ln = 3'($urandom_range(0, 7));
				offer(op, ln, 17'($urandom_range(0, 131071)));
				if (op != 2'd3 && !(op == lcd_pkg::OpVehicle && ln >= LANE_COUNT))
					counted++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// result receiver: random stalls, one long hold-off, in-order check
	// ------------------------------------------------------------------
	task automatic check_decision(input lcd_pkg::out_word_t got);
		lcd_pkg::out_word_t want;
		decisions_seen++;
		if (pending_decisions.size() == 0) begin
			$error("result word with no decision pending: state %0d lane %0d action %0d",
				got.next_state, got.target_lane_out, got.speed_action);
			mismatch_count++;
			return;
		end
		want = pending_decisions.pop_front();
		if (got.next_state !== want.next_state) begin
			$error("next_state: expected %0d, got %0d", want.next_state, got.next_state);
			mismatch_count++;
		end
		if (got.target_lane_out !== want.target_lane_out) begin
			$error("target_lane_out: expected %0d, got %0d",
				want.target_lane_out, got.target_lane_out);
			mismatch_count++;
		end
		if (got.speed_action !== want.speed_action) begin
			$error("speed_action: expected %0d, got %0d", want.speed_action, got.speed_action);
			mismatch_count++;
		end
	endtask

	initial begin : receiver
		bit nxt_ready;
		int stall_left;
		int hold_left;
		bit held_off;
		stall_left = 0;
		hold_left = 0;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				check_decision(result_ch.data);
			if (hold_left > 0) begin
				hold_left--;
				nxt_ready = 1'b0;
			end else if (!held_off && decisions_seen >= 40) begin
				// the sender keeps going while we sit here
				held_off = 1'b1;
				hold_left = LONG_HOLD;
				nxt_ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				nxt_ready = 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				stall_left = pick_gap() - 1;
				nxt_ready = 1'b0;
			end else begin
				nxt_ready = 1'b1;
			end
			result_ch.ready <= nxt_ready;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	logic [lcd_pkg::PosW-1:0]  phase_safety[PHASES];
	logic [lcd_pkg::LaneW-1:0] phase_lane[PHASES];
	int                        phase_idle[PHASES];

	initial begin : stimulus
		plan_row_t row;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = lcd_pkg::RegSafetyDistance;
		wr_data = '0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;

		// state right after reset
		safety_q = lcd_pkg::SafetyDistanceReset;
		start_lane_q = lcd_pkg::StartLaneReset;
		heading_q = lcd_pkg::StartLaneReset;
		mode_q = lcd_pkg::StFollow;
		own_lane_q = '0;
		own_pos_q = '0;
		ahead_found_q = 1'b0;
		ahead_gap_q = '0;
		lane_blocked_q = '0;

		// register settings per phase: reset values, both extremes, a few odd ones
		phase_safety = '{17'd480, 17'd0, 17'd131071, 17'($urandom_range(16, 4000)), 17'd1,
			17'($urandom_range(0, 131071))};
		phase_lane = '{3'd1, 3'd0, 3'd7, 3'($urandom_range(0, 7)), 3'd2,
			3'($urandom_range(0, 7))};
		// one phase with no idling at all on either side
		phase_idle = '{25, 15, 0, 40, 30, 20};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		build_corner_plan();
		foreach (corner_plan[i]) begin
			row = corner_plan[i];
			offer_word(row.w, row.typed, row.r);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_reg(lcd_pkg::RegSafetyDistance, phase_safety[ph]);
			// upper data bits are don't-care for the lane register
			write_reg(lcd_pkg::RegStartLane, {14'($urandom_range(0, 16383)), phase_lane[ph]});
			wr_en <= 1'b0;
			idle_pct = phase_idle[ph];
			run_traffic(WORDS_PER_PHASE);
		end

		drain();
		$display("sent %0d words (%0d corner rows), checked %0d decisions", words_sent,
			corner_plan.size(), decisions_seen);
		$display("%0d register writes over %0d settings, safety distance 0 to 131071",
			reg_writes, PHASES);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
rtl/lcd_pkg.sv
rtl/lcd_in_if.sv
rtl/lcd_out_if.sv
rtl/lane_change_decision_fsm.sv
test/tb_top.sv
